// ===== sv/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue unit.
// No dependencies; compile first.
package mhpq_pkg;

   localparam int DATA_W      = 32;
   localparam int COUNT_OUT_W = 7;

   typedef logic signed [DATA_W-1:0] data_type;

   // Operation codes carried in the request func field
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic     func;
      data_type value;
   } req_type;

   typedef struct packed {
      data_type               top_value;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   is_empty;
      logic [1:0]             status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_push;
      logic       load_pop;
      logic       take_last;
      logic       up_read;
      logic       up_move;
      logic       down_read;
      logic       down_move;
      logic       park;
      logic       rsp_load;
      status_type status_code;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic up_less;
      logic no_left;
      logic down_stop;
      logic rsp_free;
   } stat_type;

endpackage

// ===== sv/mhpq_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// No dependencies; the payload type is given per instance.
interface mhpq_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/mhpq_ctrl.sv =====
// Sequencer for push sift-up and pop sift-down.
// Depends on mhpq_pkg.
module mhpq_ctrl import mhpq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_func,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_DN_TAKE,
      ST_DN_READ,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_comb begin
      cmd             = '0;
      cmd.status_code = code_ff;
      state_in        = state_ff;
      code_in         = code_ff;
      req_ready       = (state_ff == ST_IDLE) && !reset;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               priority if (req_func == FUNC_POP && stat.empty) begin
                  code_in  = STATUS_EMPTY;
                  state_in = ST_DONE;
               end else if (req_func == FUNC_POP) begin
                  cmd.load_pop = 1'b1;
                  code_in      = STATUS_OK;
                  state_in     = ST_DN_TAKE;
               end else if (stat.full) begin
                  code_in  = STATUS_FULL;
                  state_in = ST_DONE;
               end else begin
                  cmd.load_push = 1'b1;
                  code_in       = STATUS_OK;
                  state_in      = ST_UP_CHECK;
               end
            end
         end
         ST_UP_CHECK: begin
            if (stat.at_root) begin
               cmd.park = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_less) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_CHECK;
            end else begin
               cmd.park = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DN_TAKE: begin
            cmd.take_last = 1'b1;
            state_in      = ST_DN_READ;
         end
         ST_DN_READ: begin
            if (stat.no_left) begin
               cmd.park = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.down_read = 1'b1;
               state_in      = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (stat.down_stop) begin
               cmd.park = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.down_move = 1'b1;
               state_in      = ST_DN_READ;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            cmd.rsp_load = stat.rsp_free;
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ===== sv/mhpq_dpath.sv =====
// Heap storage, moving-entry registers, child compare and output register.
// Depends on mhpq_pkg.
module mhpq_dpath import mhpq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  data_type req_value,
   output stat_type stat,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_payload
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;

   data_type mem [CAPACITY];
   data_type rd_a_ff, rd_b_ff;
   data_type v_ff, v_in;
   data_type top_ff;
   data_type wr_data;

   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] rd_a_addr, rd_b_addr;
   logic [AW-1:0] parent, last;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] lft, rgt, count_x;
   logic          lft_ok, rgt_ok, a_lt, pick_r, pick_l, wr_en;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   always_comb begin
      parent  = (pos_ff - 1'b1) >> 1;
      last    = AW'(count_ff - 1'b1);
      lft     = {1'b0, pos_ff, 1'b1};
      rgt     = lft + LW'(1);
      count_x = LW'(count_ff);
      lft_ok  = lft < count_x;
      rgt_ok  = rgt < count_x;
      a_lt    = rd_a_ff < v_ff;
      pick_r  = rgt_ok && (rd_b_ff < (a_lt ? rd_a_ff : v_ff));
      pick_l  = a_lt && !pick_r;

      priority if (cmd.load_pop) begin
         rd_a_addr = last;
      end else if (cmd.down_read) begin
         rd_a_addr = lft[AW-1:0];
      end else if (cmd.up_read) begin
         rd_a_addr = parent;
      end else begin
         rd_a_addr = '0;
      end
      priority if (rgt_ok) begin
         rd_b_addr = rgt[AW-1:0];
      end else if (lft_ok) begin
         rd_b_addr = lft[AW-1:0];
      end else begin
         rd_b_addr = '0;
      end

      wr_en = cmd.up_move || cmd.down_move || cmd.park;
      priority if (cmd.up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.down_move) begin
         wr_data = pick_r ? rd_b_ff : rd_a_ff;
      end else begin
         wr_data = v_ff;
      end

      v_in     = v_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      priority if (cmd.load_push) begin
         v_in     = req_value;
         pos_in   = AW'(count_ff);
         count_in = count_ff + 1'b1;
      end else if (cmd.load_pop) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.take_last) begin
         v_in   = rd_a_ff;
         pos_in = '0;
      end else if (cmd.up_move) begin
         pos_in = parent;
      end else if (cmd.down_move) begin
         pos_in = pick_r ? rgt[AW-1:0] : lft[AW-1:0];
      end

      stat.full      = count_x == LW'(CAPACITY);
      stat.empty     = count_ff == '0;
      stat.at_root   = pos_ff == '0;
      stat.up_less   = v_ff < rd_a_ff;
      stat.no_left   = !lft_ok;
      stat.down_stop = !(pick_l || pick_r);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;

      rsp_in.top_value   = (count_ff != '0) ? top_ff : '0;
      rsp_in.entry_count = COUNT_OUT_W'(count_ff);
      rsp_in.is_empty    = count_ff == '0;
      rsp_in.status      = cmd.status_code;

      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // heap memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      pos_ff <= pos_in;
      if (wr_en && pos_ff == '0) begin
         top_ff <= wr_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.load_push |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("push did not advance the entry count");
`endif

endmodule

// ===== sv/min_heap_priority_queue_unit.sv =====
// Top level of the min-heap priority queue: controller plus datapath.
// Depends on mhpq_pkg, mhpq_stream_if, mhpq_ctrl and mhpq_dpath.
//
//   channel | modport | payload  | direction
//   --------+---------+----------+----------------------------------
//   req_if  | sink    | req_type | push/pop transaction in
//   rsp_if  | source  | rsp_type | top value, count, empty, status out
//
// A push climbs one level per compare and stops at the root or below a parent
// that is not greater; a pop moves the last entry to the root and descends until
// it has no left child or no child is smaller; a refused push or pop goes straight
// to the hand-off. At a capacity of 64 a push climbs at most six levels.
// Reset clears the entry count and the output valid flag; storage and the output payload are not swept.
// The next request is taken while a result waits; the one after stalls until it goes.
module min_heap_priority_queue_unit import mhpq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic           clock,
   input logic           reset,
   mhpq_stream_if.sink   req_if,
   mhpq_stream_if.source rsp_if
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   // Sequence each transaction: decide refusal, walk the sift, then hand off
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.payload.func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold storage, the moving entry, the root shadow and the response register
   mhpq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_value   (req_if.payload.value),
      .stat        (stat),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_payload (rsp_if.payload)
   );

   assign req_if.ready = req_ready;

endmodule

// ===== tb/sv/mhpq_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the min-heap priority queue: watches both channels, keeps a
// heap model of its own and checks every result. Depends on mhpq_pkg.
module mhpq_checker import mhpq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      error_count,
   output int      pending_count
);

   data_type    heap_vals [CAPACITY];
   int unsigned heap_size;
   rsp_type     awaited_results [$];

   // Apply one push or pop to the heap model and return the result it gives.
   function automatic rsp_type apply_request(req_type rq);
      rsp_type     res;
      status_type  st;
      int unsigned pos;
      int unsigned parent;
      int unsigned best;
      int unsigned lc;
      int unsigned rc;
      data_type    tmp;
      st = STATUS_OK;
      if (rq.func == FUNC_PUSH) begin
         if (heap_size >= CAPACITY) begin
            st = STATUS_FULL;
         end else begin
            pos = heap_size;
            heap_vals[pos] = rq.value;
            heap_size++;
            while (pos != 0) begin
               parent = (pos - 1) / 2;
               if (!(heap_vals[pos] < heap_vals[parent]))
                  break;
               tmp = heap_vals[pos];
               heap_vals[pos] = heap_vals[parent];
               heap_vals[parent] = tmp;
               pos = parent;
            end
         end
      end else begin
         if (heap_size == 0) begin
            st = STATUS_EMPTY;
         end else begin
            heap_size--;
            heap_vals[0] = heap_vals[heap_size];
            pos = 0;
            while (pos < heap_size) begin
               best = pos;
               lc = 2 * pos + 1;
               rc = 2 * pos + 2;
               // strict compares: a tie keeps the parent, and the left child wins
               if (lc < heap_size && heap_vals[lc] < heap_vals[best])
                  best = lc;
               if (rc < heap_size && heap_vals[rc] < heap_vals[best])
                  best = rc;
               if (best == pos)
                  break;
               tmp = heap_vals[pos];
               heap_vals[pos] = heap_vals[best];
               heap_vals[best] = tmp;
               pos = best;
            end
         end
      end
      res.top_value   = (heap_size != 0) ? heap_vals[0] : '0;
      res.entry_count = heap_size[COUNT_OUT_W-1:0];
      res.is_empty    = (heap_size == 0);
      res.status      = st;
      return res;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
      heap_size     = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         heap_size = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && req_ready)
            awaited_results = {awaited_results, apply_request(req_payload)};
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result with no request outstanding: top_value %0d",
                      $signed(rsp_payload.top_value));
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_payload.top_value !== want.top_value) begin
                  $error("top_value: expected %0d, actual %0d",
                         $signed(want.top_value), $signed(rsp_payload.top_value));
                  error_count++;
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_payload.entry_count);
                  error_count++;
               end
               if (rsp_payload.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d",
                         want.is_empty, rsp_payload.is_empty);
                  error_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_payload.status);
                  error_count++;
               end
            end
         end
      end
      pending_count <= awaited_results.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the min-heap priority queue testbench: clock, reset, stimulus and
// verdict. Depends on mhpq_pkg, mhpq_stream_if, the unit and mhpq_checker.
module tb;
   import mhpq_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 530;
   localparam int SETTLE_WAIT  = 40;    // extra wait after the final drain, in cycles
   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles

   typedef enum int { BURST_MIX, BURST_FILL, BURST_DRAIN } burst_kind_type;

   logic clock;
   logic reset;

   mhpq_stream_if #(.payload_type(req_type)) req_if ();
   mhpq_stream_if #(.payload_type(rsp_type)) rsp_if ();

   int error_count;
   int pending_results;

   // Idle rates in percent; the stimulus switches them between phases.
   int send_idle_pct = 13;
   int recv_idle_pct = 75;

   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit long_hold_request = 1'b0;

   // Occupancy as seen by the sender, only used to steer fill and drain bursts.
   int occupancy = 0;

   min_heap_priority_queue_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   mhpq_checker #(.CAPACITY(CAPACITY)) heap_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .error_count   (error_count),
      .pending_count (pending_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard limit: far beyond the slowest correct run at the worst idle rates,
   // including the long hold-off.
   initial begin
      #2_500_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: drop ready at random at the current idle rate, and hold it
   // low for a long stretch when asked, counting the cycles here.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            hold_left = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Mix of full-range values, a narrow band that gives many ties, the
   // extremes of the signed range, zero and minus one.
   function automatic data_type pick_value();
      data_type v;
      case ($urandom_range(0, 9))
         5, 6, 7: v = $signed($urandom_range(0, 15)) - 8;
         8: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = '0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Offer one transaction at a falling edge and hold it until accepted.
   // Valid stays high into the next offer unless a gap is drawn.
   task automatic offer(input logic fn, input data_type v);
      req_type item;
      item.func  = fn;
      item.value = v;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      if (fn == FUNC_PUSH) begin
         if (occupancy < CAPACITY)
            occupancy++;
      end else if (occupancy > 0) begin
         occupancy--;
      end
      @(negedge clock);
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0)
         @(negedge clock);
   endtask

   initial begin
      burst_kind_type burst_kind;
      int             burst_left;
      int             held_idle;
      logic           fn;

      burst_kind     = BURST_MIX;
      burst_left     = 0;
      held_idle      = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: pop on an empty heap, the signed extremes, ties at the
      // minimum and between siblings, a full drain and another empty pop.
      offer(FUNC_POP,  32'sh7FFF_FFFF);
      offer(FUNC_PUSH, 0);
      offer(FUNC_PUSH, 32'sh7FFF_FFFF);
      offer(FUNC_PUSH, 32'sh8000_0000);
      offer(FUNC_PUSH, -1);
      offer(FUNC_PUSH, 1);
      offer(FUNC_PUSH, 32'sh8000_0000);
      offer(FUNC_PUSH, 5);
      offer(FUNC_PUSH, 5);
      offer(FUNC_PUSH, 3);
      repeat (9) offer(FUNC_POP, 32'sh8000_0000);
      offer(FUNC_POP, -1);
      offer(FUNC_PUSH, -5);
      offer(FUNC_POP, 0);

      // Random: bursts that fill the heap past capacity or drain it past
      // empty, between stretches of mixed traffic.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 75;
            recv_idle_pct = 13;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Long receiver hold-off while the sender keeps offering back to back,
         // so that the block backs up and stalls its input.
         if (n == 100) begin
            held_idle         = send_idle_pct;
            send_idle_pct     = 0;
            long_hold_request = 1'b1;
         end
         if (n == 125)
            send_idle_pct = held_idle;
         // Pause the sender until every result is back.
         if (n == 260)
            drain_results();

         if (burst_left == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  burst_kind = BURST_FILL;
                  burst_left = CAPACITY - occupancy + $urandom_range(1, 3);
               end
               1: begin
                  burst_kind = BURST_DRAIN;
                  burst_left = occupancy + $urandom_range(1, 3);
               end
               default: begin
                  burst_kind = BURST_MIX;
                  burst_left = $urandom_range(10, 40);
               end
            endcase
         end
         case (burst_kind)
            BURST_FILL:  fn = FUNC_PUSH;
            BURST_DRAIN: fn = FUNC_POP;
            default:     fn = ($urandom_range(0, 99) < 60) ? FUNC_PUSH : FUNC_POP;
         endcase
         burst_left--;
         offer(fn, pick_value());
      end

      // Drain, then allow a little extra time for any stray result.
      drain_results();
      repeat (SETTLE_WAIT) @(negedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
